[rtl/core/assert_macros.svh]
// Assertion macros used by the checker of the sorted list unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLRI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted list check failed");

// The consequent must hold in the cycle after the antecedent.
`define SLRI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted list check failed");

`endif

[rtl/core/slri_pkg.sv]
// Shared constants, codes and types of the sorted list unit.
package slri_pkg;

  localparam int CAPACITY      = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int DATA_W        = 32;
  localparam int IDXW          = $clog2(CAPACITY);
  localparam int CNTW          = $clog2(CAPACITY + 1);
  localparam int ENTRY_COUNT_W = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_HEAD,
    ST_REM,
    ST_DUMP,
    ST_RESP
  } state_t;

  // One result word handed from the sequencer to the output register.
  typedef struct packed {
    logic                     load;
    status_t                  status;
    logic [DATA_W-1:0]        entry_value;
    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     last;
  } res_t;

endpackage

[rtl/core/sorted_list_insert_remove_unit.sv]
// Top level of the sorted list unit: sequencer, entry memory and output register.
// Insert scans down from the top entry and remove scans the whole list; a dump streams one
// word per cycle while the output register is free, and the next command is taken only
// after the last word.
// Reset clears the entry count, the sequencer and the output valid; memory contents
// are left as they are and never read before being written.
module sorted_list_insert_remove_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         command,
  input  logic signed [slri_pkg::DATA_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         status,
  output logic signed [slri_pkg::DATA_W-1:0] entry_value,
  output logic [slri_pkg::ENTRY_COUNT_W-1:0] entry_count,
  output logic                               last
);

  slri_pkg::res_t                res;
  logic                          out_free;
  logic                          mem_we, mem_re;
  logic [slri_pkg::IDXW-1:0]     mem_waddr, mem_raddr;
  logic [slri_pkg::DATA_W-1:0]   mem_wdata, mem_rdata;

  assign out_free = !out_valid || out_ready;

  slri_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .value     (value),
    .out_free  (out_free),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  slri_ram #(
    .DEPTH (slri_pkg::CAPACITY),
    .WIDTH (slri_pkg::DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      status      <= res.status;
      entry_value <= res.entry_value;
      entry_count <= res.entry_count;
      last        <= res.last;
    end
  end

endmodule

[rtl/core/slri_ram.sv]
// Generic simple dual-port RAM with registered read.
module slri_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/slri_ctrl.sv]
// Sequencer that walks the entry memory for insert, remove and dump.
module slri_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        command,
  input  logic signed [slri_pkg::DATA_W-1:0] value,
  input  logic                              out_free,
  output slri_pkg::res_t                    res,
  output logic                              mem_we,
  output logic [slri_pkg::IDXW-1:0]         mem_waddr,
  output logic [slri_pkg::DATA_W-1:0]       mem_wdata,
  output logic                              mem_re,
  output logic [slri_pkg::IDXW-1:0]         mem_raddr,
  input  logic [slri_pkg::DATA_W-1:0]       mem_rdata
);

  slri_pkg::state_t  state, state_next;
  slri_pkg::cmd_t    cmd;
  slri_pkg::status_t res_status;

  logic signed [slri_pkg::DATA_W-1:0] cmd_val;
  logic [slri_pkg::CNTW-1:0]          held_count;
  logic [slri_pkg::CNTW-1:0]          dump_lim;
  logic [slri_pkg::IDXW-1:0]          idx;
  logic                               found;

  logic                      ins_le, rem_hit, rem_last, dump_last;
  logic                      idx_is_one, list_full, list_empty;
  logic [slri_pkg::CNTW-1:0] idx_inc;
  logic [slri_pkg::IDXW-1:0] idx_dec;

  assign cmd        = slri_pkg::cmd_t'(command);
  assign ins_le     = cmd_val <= $signed(mem_rdata);
  assign rem_hit    = mem_rdata == cmd_val;
  assign idx_inc    = slri_pkg::CNTW'(idx) + slri_pkg::CNTW'(1);
  assign idx_dec    = idx - slri_pkg::IDXW'(1);
  assign idx_is_one = idx == slri_pkg::IDXW'(1);
  assign rem_last   = idx_inc == held_count;
  assign dump_last  = idx_inc == dump_lim;
  assign list_full  = held_count >= slri_pkg::CNTW'(slri_pkg::CAPACITY);
  assign list_empty = held_count == '0;

  always_comb begin
    state_next = state;
    case (state)
      slri_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            slri_pkg::CMD_INSERT: begin
              state_next = (list_full || list_empty) ? slri_pkg::ST_RESP : slri_pkg::ST_INS;
            end
            slri_pkg::CMD_REMOVE: begin
              state_next = list_empty ? slri_pkg::ST_RESP : slri_pkg::ST_REM;
            end
            slri_pkg::CMD_DUMP: begin
              state_next = list_empty ? slri_pkg::ST_RESP : slri_pkg::ST_DUMP;
            end
            default: begin
              state_next = slri_pkg::ST_RESP;
            end
          endcase
        end
      end
      slri_pkg::ST_INS: begin
        if (!ins_le) begin
          state_next = slri_pkg::ST_RESP;
        end else if (idx_is_one) begin
          state_next = slri_pkg::ST_INS_HEAD;
        end
      end
      slri_pkg::ST_INS_HEAD: begin
        state_next = slri_pkg::ST_RESP;
      end
      slri_pkg::ST_REM: begin
        if (rem_last) begin
          state_next = slri_pkg::ST_RESP;
        end
      end
      slri_pkg::ST_DUMP: begin
        if (out_free && dump_last) begin
          state_next = slri_pkg::ST_IDLE;
        end
      end
      slri_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = slri_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = slri_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = idx_dec - slri_pkg::IDXW'(1);
    res       = '0;
    case (state)
      slri_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (cmd)
            slri_pkg::CMD_INSERT: begin
              if (list_empty) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = value;
              end else if (!list_full) begin
                // Start the scan from the top entry downward.
                mem_re    = 1'b1;
                mem_raddr = slri_pkg::IDXW'(held_count - slri_pkg::CNTW'(1));
              end
            end
            slri_pkg::CMD_REMOVE, slri_pkg::CMD_DUMP: begin
              mem_re    = !list_empty;
              mem_raddr = '0;
            end
            default: begin
              mem_re = 1'b0;
            end
          endcase
        end
      end
      slri_pkg::ST_INS: begin
        // Entries not below the new value move up by one; the first smaller
        // entry marks the slot for the new value.
        mem_we = 1'b1;
        if (ins_le) begin
          mem_re = !idx_is_one;
        end else begin
          mem_wdata = cmd_val;
        end
      end
      slri_pkg::ST_INS_HEAD: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = cmd_val;
      end
      slri_pkg::ST_REM: begin
        // After the match every later entry moves down by one.
        mem_we    = found;
        mem_waddr = idx_dec;
        mem_re    = !rem_last;
        mem_raddr = slri_pkg::IDXW'(idx_inc);
      end
      slri_pkg::ST_DUMP: begin
        if (out_free) begin
          res.load        = 1'b1;
          res.status      = slri_pkg::STS_OK;
          res.entry_value = mem_rdata;
          res.entry_count = slri_pkg::ENTRY_COUNT_W'(held_count);
          res.last        = dump_last;
          mem_re          = !dump_last;
          mem_raddr       = slri_pkg::IDXW'(idx_inc);
        end
      end
      slri_pkg::ST_RESP: begin
        if (out_free) begin
          res.load        = 1'b1;
          res.status      = res_status;
          res.entry_count = slri_pkg::ENTRY_COUNT_W'(held_count);
          res.last        = 1'b1;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= slri_pkg::ST_IDLE;
      held_count <= '0;
    end else begin
      state <= state_next;
      case (state)
        slri_pkg::ST_IDLE: begin
          if (in_valid) begin
            case (cmd)
              slri_pkg::CMD_INSERT: begin
                if (!list_full) begin
                  held_count <= held_count + slri_pkg::CNTW'(1);
                end
              end
              slri_pkg::CMD_CLEAR: begin
                held_count <= '0;
              end
              default: begin
                held_count <= held_count;
              end
            endcase
          end
        end
        slri_pkg::ST_REM: begin
          if (rem_last && (found || rem_hit)) begin
            held_count <= held_count - slri_pkg::CNTW'(1);
          end
        end
        default: begin
          held_count <= held_count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      slri_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_val    <= value;
          found      <= 1'b0;
          res_status <= slri_pkg::STS_OK;
          case (cmd)
            slri_pkg::CMD_INSERT: begin
              idx <= slri_pkg::IDXW'(held_count);
              if (list_full) begin
                res_status <= slri_pkg::STS_FULL;
              end
            end
            slri_pkg::CMD_REMOVE: begin
              idx <= '0;
              if (list_empty) begin
                res_status <= slri_pkg::STS_EMPTY;
              end
            end
            slri_pkg::CMD_DUMP: begin
              idx <= '0;
              if (list_empty) begin
                res_status <= slri_pkg::STS_EMPTY;
              end
              if (int'(held_count) > slri_pkg::MAX_RESULTS) begin
                dump_lim <= slri_pkg::CNTW'(slri_pkg::MAX_RESULTS);
              end else begin
                dump_lim <= held_count;
              end
            end
            default: begin
              idx <= '0;
            end
          endcase
        end
      end
      slri_pkg::ST_INS: begin
        idx <= idx_dec;
      end
      slri_pkg::ST_REM: begin
        idx <= slri_pkg::IDXW'(idx_inc);
        if (rem_hit) begin
          found <= 1'b1;
        end
        if (rem_last && !(found || rem_hit)) begin
          res_status <= slri_pkg::STS_NOT_FOUND;
        end
      end
      slri_pkg::ST_DUMP: begin
        if (out_free) begin
          idx <= slri_pkg::IDXW'(idx_inc);
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

endmodule

[rtl/core/slri_chk.sv]
// Port-level checker for the sorted list unit, bound to the top level.
`include "assert_macros.svh"

module slri_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [1:0]                         command,
  input logic signed [slri_pkg::DATA_W-1:0] value,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [1:0]                         status,
  input logic signed [slri_pkg::DATA_W-1:0] entry_value,
  input logic [slri_pkg::ENTRY_COUNT_W-1:0] entry_count,
  input logic                               last
);

  logic                               in_wait, out_wait, err_word, full_word;
  logic [slri_pkg::ENTRY_COUNT_W-1:0] full_count;

  assign in_wait    = in_valid && !in_ready;
  assign out_wait   = out_valid && !out_ready;
  assign err_word   = out_valid && (status != slri_pkg::STS_OK);
  assign full_word  = out_valid && (status == slri_pkg::STS_FULL);
  assign full_count = slri_pkg::ENTRY_COUNT_W'(slri_pkg::CAPACITY);

  // A command word that waits must not move.
  `SLRI_ASSERT_NEXT(a_in_hold, clk, rst, in_wait, in_valid && $stable(command) && $stable(value))

  // A result word that waits must not move.
  `SLRI_ASSERT_NEXT(a_out_hold, clk, rst, out_wait, out_valid && $stable(entry_value) && $stable(last))

  // Error words carry no entry and end the response.
  `SLRI_ASSERT_NOW(a_err_last, clk, rst, err_word, last && entry_value == '0)

  // A full report only happens with the list at capacity.
  `SLRI_ASSERT_NOW(a_full_cnt, clk, rst, full_word, entry_count == full_count)

  // No new word is taken while a dump is still streaming.
  `SLRI_ASSERT_NOW(a_dump_busy, clk, rst, out_valid && !last, !in_ready)

endmodule

bind sorted_list_insert_remove_unit slri_chk u_chk (.*);
